/* rtl/core/sitd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the binary to BCD step for the integer to ASCII core.
package sitd_pkg;

    localparam int VALUE_W     = 32;
    localparam int DIGITS      = 10;
    localparam int BCD_W       = DIGITS * 4;
    localparam int STEP_BITS   = 8;
    localparam int NUM_STAGES  = VALUE_W / STEP_BITS;
    localparam int IDX_W       = 4;
    localparam int CHAR_W      = 6;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    typedef struct packed {
        logic               neg;
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
    } word_t;

    function automatic word_t dabble_step(input word_t w);
        word_t r;
        logic [BCD_W-1:0] adj;
        r = w;
        for (int d = 0; d < DIGITS; d++)
        begin
            if (w.bcd[d*4 +: 4] >= 4'd5)
            begin
                adj[d*4 +: 4] = w.bcd[d*4 +: 4] + 4'd3;
            end
            else
            begin
                adj[d*4 +: 4] = w.bcd[d*4 +: 4];
            end
        end
        r.bcd = {adj[BCD_W-2:0], w.bin[VALUE_W-1]};
        r.bin = {w.bin[VALUE_W-2:0], 1'b0};
        return r;
    endfunction

endpackage

/* rtl/core/sitd_dabble_stage.sv */
`timescale 1ns / 1ps
// One pipeline stage of the binary to BCD converter: several shift-and-adjust steps.
module sitd_dabble_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  sitd_pkg::word_t in_word,
    output logic            in_ready,
    output logic            out_valid,
    output sitd_pkg::word_t out_word,
    input  logic            out_ready
);

    logic            valid_reg;
    sitd_pkg::word_t word_reg;
    sitd_pkg::word_t word_next;
    logic            load;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    always_comb
    begin
        word_next = in_word;
        for (int s = 0; s < sitd_pkg::STEP_BITS; s++)
        begin
            word_next = sitd_pkg::dabble_step(word_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

/* rtl/core/sitd_serializer.sv */
`timescale 1ns / 1ps
// Character serializer: emits sign and significant BCD digits one per cycle.
module sitd_serializer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  sitd_pkg::word_t               in_word,
    output logic                          in_ready,
    output logic                          char_strobe,
    output logic [sitd_pkg::CHAR_W-1:0]   char_code,
    output logic                          last_char
);

    logic                            active_reg;
    logic                            minus_reg;
    logic [sitd_pkg::IDX_W-1:0]      idx_reg;
    logic [sitd_pkg::BCD_W-1:0]      bcd_reg;
    logic [sitd_pkg::IDX_W-1:0]      top_idx;
    logic                            final_now;
    logic                            load;
    logic [3:0]                      digit;

    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < sitd_pkg::DIGITS; i++)
        begin
            if (in_word.bcd[i*4 +: 4] != 4'd0)
            begin
                top_idx = sitd_pkg::IDX_W'(i);
            end
        end
    end

    assign final_now = active_reg && !minus_reg && (idx_reg == '0);
    assign in_ready  = !active_reg || final_now;
    assign load      = in_ready && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            minus_reg  <= 1'b0;
            idx_reg    <= '0;
        end
        else if (load)
        begin
            active_reg <= 1'b1;
            minus_reg  <= in_word.neg;
            idx_reg    <= top_idx;
        end
        else if (final_now)
        begin
            active_reg <= 1'b0;
        end
        else if (active_reg)
        begin
            if (minus_reg)
            begin
                minus_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bcd_reg <= in_word.bcd;
        end
    end

    assign digit       = bcd_reg[idx_reg*4 +: 4];
    assign char_strobe = active_reg;
    assign char_code   = minus_reg ? sitd_pkg::CHAR_MINUS
                                   : sitd_pkg::CHAR_ZERO + {2'b00, digit};
    assign last_char   = final_now;

endmodule

/* rtl/core/signed_int_to_decimal_ascii_core.sv */
`timescale 1ns / 1ps
// Top level: signed 32-bit integer to decimal ASCII text, one character per cycle.
//
//  Channel  Signals                        Direction  Handshake
//  input    start, busy, value[31:0]       in         taken when start && !busy
//  output   char_strobe, char_code[5:0],   out        one strobe per character,
//           last_char                                 no back-pressure
//
//  Path: 1 magnitude stage + 4 BCD stages, then 1 to 11 characters.
//  The serializer emits one character per cycle; a value occupies it until its last
//  character, which sets the sustained rate. Items queue in the five stages meanwhile.
//  busy rises when the magnitude stage is full and cannot advance.
//  rst_n clears all valid bits asynchronously; payload registers are not reset.
module signed_int_to_decimal_ascii_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [31:0]            value,
    output logic                          char_strobe,
    output logic [sitd_pkg::CHAR_W-1:0]   char_code,
    output logic                          last_char
);

    logic            s0_valid_reg;
    sitd_pkg::word_t s0_word_reg;
    sitd_pkg::word_t s0_word_next;
    logic            s0_load;

    logic            st_valid [0:sitd_pkg::NUM_STAGES];
    sitd_pkg::word_t st_word  [0:sitd_pkg::NUM_STAGES];
    logic            st_ready [0:sitd_pkg::NUM_STAGES];

    assign s0_load = !s0_valid_reg || st_ready[0];
    assign busy    = !s0_load;

    always_comb
    begin
        s0_word_next.neg = value[31];
        s0_word_next.bcd = '0;
        s0_word_next.bin = value[31] ? (32'd0 - 32'(value)) : 32'(value);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_load)
        begin
            s0_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_load && start)
        begin
            s0_word_reg <= s0_word_next;
        end
    end

    assign st_valid[0] = s0_valid_reg;
    assign st_word[0]  = s0_word_reg;

    for (genvar g = 0; g < sitd_pkg::NUM_STAGES; g++)
    begin : g_dabble
        sitd_dabble_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[g]),
            .in_word   (st_word[g]),
            .in_ready  (st_ready[g]),
            .out_valid (st_valid[g+1]),
            .out_word  (st_word[g+1]),
            .out_ready (st_ready[g+1])
        );
    end

    sitd_serializer u_ser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (st_valid[sitd_pkg::NUM_STAGES]),
        .in_word     (st_word[sitd_pkg::NUM_STAGES]),
        .in_ready    (st_ready[sitd_pkg::NUM_STAGES]),
        .char_strobe (char_strobe),
        .char_code   (char_code),
        .last_char   (last_char)
    );

endmodule
